// File: sv/csv_stream_tokenizer_assert.svh
// Assertion macros for the CSV tokenizer.
`ifndef CSV_STREAM_TOKENIZER_ASSERT_SVH
`define CSV_STREAM_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, off while reset is asserted.
`define CST_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csv tokenizer check failed");

// Clocked check that also runs through reset.
`define CST_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("csv tokenizer check failed");

`else

`define CST_ASSERT(lbl, clk, rst_n, prop)
`define CST_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: sv/cst_pkg.sv
`timescale 1ns / 1ps

package cst_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNTERM  = 2'd1,
    ERR_BAD_SEP = 2'd2,
    ERR_LONE_CR = 2'd3
  } cst_err_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } cst_item_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] char_out;
    logic       field_end;
    logic       record_end;
    cst_err_t   error_code;
  } cst_res_t;

endpackage

// File: sv/cst_if.sv
`timescale 1ns / 1ps

interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface cst_out_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] char_out;
  logic       field_end;
  logic       record_end;
  logic [1:0] error_code;

  modport source (output valid, output has_char, output char_out, output field_end,
                  output record_end, output error_code, input ready);
  modport sink (input valid, input has_char, input char_out, input field_end,
                input record_end, input error_code, output ready);
endinterface

// File: sv/cst_in_reg.sv
`timescale 1ns / 1ps

module cst_in_reg
  import cst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  cst_item_t in_item,
  output logic      in_ready,
  input  logic      take,
  output logic      vld,
  output cst_item_t item
);

  logic      vld_r;
  cst_item_t item_r;

  assign in_ready = !vld_r || take;
  assign vld      = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// File: sv/cst_fsm.sv
`timescale 1ns / 1ps

module cst_fsm
  import cst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      vld,
  input  cst_item_t item,
  output logic      take,
  output logic      out_valid,
  output cst_res_t  out_res,
  input  logic      out_ready
);

  typedef enum logic [2:0] {
    S_START  = 3'd0,
    S_LIT    = 3'd1,
    S_QUOTED = 3'd2,
    S_QSEEN  = 3'd3,
    S_CR     = 3'd4,
    S_DRAIN  = 3'd5
  } state_t;

  state_t   state_r, state_nxt;
  logic     out_valid_r;
  cst_res_t out_res_r;
  cst_res_t res;
  logic     emit;
  logic     out_free;
  logic     last;
  logic [7:0] b;
  logic     is_q, is_c, is_lf, is_cr;

  assign b     = item.in_byte;
  assign last  = item.in_last;
  assign is_q  = (b == CH_QUOTE);
  assign is_c  = (b == CH_COMMA);
  assign is_lf = (b == CH_LF);
  assign is_cr = (b == CH_CR);

  assign out_free  = !out_valid_r || out_ready;
  assign take      = vld && out_free;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    res       = '0;
    res.error_code = ERR_NONE;
    case (state_r)
      S_QUOTED: begin
        if (is_q) begin
          if (last) begin
            state_nxt = S_START;
            emit = 1'b1;
            res.field_end  = 1'b1;
            res.record_end = 1'b1;
          end else begin
            state_nxt = S_QSEEN;
          end
        end else if (last) begin
          state_nxt = S_START;
          emit = 1'b1;
          res.error_code = ERR_UNTERM;
        end else begin
          emit = 1'b1;
          res.has_char = 1'b1;
          res.char_out = b;
        end
      end
      S_CR: begin
        emit = 1'b1;
        state_nxt = S_START;
        if (is_lf) begin
          res.field_end  = 1'b1;
          res.record_end = 1'b1;
        end else begin
          res.error_code = ERR_LONE_CR;
          if (!last) state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = last ? S_START : S_DRAIN;
      end
      default: begin
        // field start, literal field and after a closing quote share separators
        if (is_q && state_r != S_LIT) begin
          if (state_r == S_QSEEN) begin
            emit = 1'b1;
            if (last) begin
              state_nxt = S_START;
              res.error_code = ERR_UNTERM;
            end else begin
              state_nxt = S_QUOTED;
              res.has_char = 1'b1;
              res.char_out = CH_QUOTE;
            end
          end else if (last) begin
            state_nxt = S_START;
            emit = 1'b1;
            res.error_code = ERR_UNTERM;
          end else begin
            state_nxt = S_QUOTED;
          end
        end else if (is_c) begin
          state_nxt = S_START;
          emit = 1'b1;
          res.field_end  = 1'b1;
          res.record_end = last;
        end else if (is_lf) begin
          state_nxt = S_START;
          emit = 1'b1;
          res.field_end  = 1'b1;
          res.record_end = 1'b1;
        end else if (is_cr) begin
          if (last) begin
            state_nxt = S_START;
            emit = 1'b1;
            res.error_code = ERR_LONE_CR;
          end else begin
            state_nxt = S_CR;
          end
        end else if (state_r == S_QSEEN) begin
          emit = 1'b1;
          res.error_code = ERR_BAD_SEP;
          state_nxt = last ? S_START : S_DRAIN;
        end else begin
          emit = 1'b1;
          res.has_char = 1'b1;
          res.char_out = b;
          if (last) begin
            state_nxt = S_START;
            res.field_end  = 1'b1;
            res.record_end = 1'b1;
          end else begin
            state_nxt = S_LIT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_START;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        out_valid_r <= take && emit;
      end
      if (take && emit) begin
        out_res_r <= res;
      end
    end
  end

endmodule

// File: sv/csv_stream_tokenizer.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat payload
// in_ch    in   in_byte[7:0], in_last
// out_ch   out  has_char, char_out[7:0], field_end, record_end, error_code[1:0]
//
// One byte per cycle while out_ch does not stall; a byte passes the input register,
// then the result register behind the parse state, before its result is on out_ch.
// Bytes that produce nothing (opening quote, quote inside a quoted field, CR,
// dropped bytes) give no beat.
// rst_n is synchronous, active low; it returns the parser to field start.
// A stalled out_ch holds the result; one more byte is buffered meanwhile.

`include "csv_stream_tokenizer_assert.svh"

module csv_stream_tokenizer
  import cst_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  cst_in_if.sink  in_ch,
  cst_out_if.source out_ch
);

  cst_item_t in_item;
  cst_item_t item;
  cst_res_t  res;
  logic      vld;
  logic      take;
  logic      out_valid;

  assign in_item.in_byte = in_ch.in_byte;
  assign in_item.in_last = in_ch.in_last;

  cst_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .in_ready (in_ch.ready),
    .take     (take),
    .vld      (vld),
    .item     (item)
  );

  cst_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld       (vld),
    .item      (item),
    .take      (take),
    .out_valid (out_valid),
    .out_res   (res),
    .out_ready (out_ch.ready)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.has_char   = res.has_char;
  assign out_ch.char_out   = res.char_out;
  assign out_ch.field_end  = res.field_end;
  assign out_ch.record_end = res.record_end;
  assign out_ch.error_code = res.error_code;

  `CST_ASSERT(a_err_alone, clk, rst_n,
    out_ch.valid && (out_ch.error_code != ERR_NONE) |->
      !out_ch.has_char && !out_ch.field_end && !out_ch.record_end)
  `CST_ASSERT(a_rec_has_field, clk, rst_n,
    out_ch.valid && out_ch.record_end |-> out_ch.field_end)
  `CST_ASSERT(a_in_stall, clk, rst_n,
    !in_ch.ready |-> vld && out_ch.valid && !out_ch.ready)
  `CST_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_ch.valid)

endmodule
